### src/ostb_pkg.sv
`default_nettype none
package ostb_pkg;

	localparam int NUM_TIMERS_DEF = 16;

	localparam int DATA_W   = 32;
	localparam int TICK_W   = 20;
	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 4;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 40;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [DATA_W-1:0] CPU_HZ_RST  = 32'd48000000;
	localparam logic [TICK_W-1:0] TICK_HZ_RST = 20'd1000;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SETUP = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_POLL  = 2'd3
	} action_t;

	// Register indexes, taken from paddr bit 2.
	typedef enum logic {
		REG_CPU_HZ  = 1'b0,
		REG_TICK_HZ = 1'b1
	} reg_index_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECIDE = 8'b0000_0010,
		ST_MUL1   = 8'b0000_0100,
		ST_DIV1   = 8'b0000_1000,
		ST_MUL2   = 8'b0001_0000,
		ST_DIV2   = 8'b0010_0000,
		ST_APPLY  = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

endpackage
`default_nettype wire

### src/one_shot_timer_bank_top.sv
// Sequence: setup, stop, an ignored start and a poll that needs no time update go IDLE,
// DECIDE, FIN; an advance of the time base adds MUL1, DIV1, MUL2, DIV2 and APPLY before FIN.
// Throughput: one item at a time; an advance runs two 32-step divisions on one shared
// bit-serial divider plus two passes through one shared 32x32 multiplier.
// Reset (arst_n low): rate registers to defaults, time and base to zero, all timers idle.
// The deadline memory is not cleared; an entry is only used after a start has written it.
`default_nettype none
module one_shot_timer_bank_top
	import ostb_pkg::*;
#(
	parameter int NumTimers = NUM_TIMERS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// APB configuration port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [PADDR_W-1:0]     paddr,
	input  wire logic [PDATA_W-1:0]     pwdata,
	output logic      [PDATA_W-1:0]     prdata,
	output logic                        pready,
	// Input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// s_tdata: action[1:0], timer_index[5:2], delay_value[37:6], cycle_count[69:38], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// Output stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// m_tdata: expired[0], time_now[32:1], zero pad
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
	localparam int CntW = $clog2(DATA_W);
	localparam logic [CntW-1:0] LastStep = CntW'(DATA_W - 1);
	localparam logic [8:0] NumTimers9 = 9'(NumTimers);

	// Configuration
	logic [DATA_W-1:0] cpu_hz_q;
	logic [TICK_W-1:0] tick_hz_q;
	logic              cfg_wr;
	reg_index_t        cfg_idx;

	// Control and architectural state
	state_t                 state_q;
	logic [CntW-1:0]        cnt_q;
	logic [NumTimers-1:0]   running_q;
	logic [NumTimers-1:0]   mark_q;
	logic [DATA_W-1:0]      tod_q;
	logic [DATA_W-1:0]      base_q;
	logic                   m_tvalid_q;

	// Item and datapath registers
	action_t                act_q;
	logic [INDEX_W-1:0]     idx_q;
	logic [DATA_W-1:0]      delay_q;
	logic [DATA_W-1:0]      now_q;
	logic [DATA_W-1:0]      dnum_q;
	logic [DATA_W-1:0]      drem_q;
	logic [DATA_W-1:0]      ticks_q;
	logic                   out_exp_q;
	logic [DATA_W-1:0]      out_time_q;

	// Deadline memory
	logic [DATA_W-1:0]      dl_mem [NumTimers];
	logic [DATA_W-1:0]      dl_rdata_q;
	logic [IdxW-1:0]        rd_addr;
	logic [IdxW-1:0]        addr_q;
	logic [8:0]             rd_idx_ext;
	logic [8:0]             idx_ext;

	logic                   in_xfer;
	logic                   idx_valid;
	logic                   cur_running;
	logic                   cur_mark;
	logic                   out_free;

	logic [DATA_W-1:0]      mul_a;
	logic [DATA_W-1:0]      mul_b;
	logic [DATA_W-1:0]      mul_p;
	logic [DATA_W-1:0]      div_den;
	logic [DATA_W:0]        div_shift;
	logic [DATA_W+1:0]      div_diff;
	logic                   div_ge;
	logic [DATA_W-1:0]      div_rem_next;
	logic [DATA_W-1:0]      ticks_sel;
	logic [DATA_W-1:0]      cyc_sel;
	logic [DATA_W-1:0]      poll_diff;
	logic                   poll_hit;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_index_t'(paddr[2]);

	always_comb begin
		case (cfg_idx)
			REG_CPU_HZ:  prdata = cpu_hz_q;
			REG_TICK_HZ: prdata = {{(PDATA_W-TICK_W){1'b0}}, tick_hz_q};
			default:     prdata = '0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, out_time_q, out_exp_q};
	assign out_free = ~m_tvalid_q | m_tready;

	assign rd_idx_ext = {5'b0, s_tdata[5:2]};
	assign rd_addr    = rd_idx_ext[IdxW-1:0];
	assign idx_ext    = {5'b0, idx_q};
	assign addr_q     = idx_ext[IdxW-1:0];
	assign idx_valid  = idx_ext < NumTimers9;
	assign cur_running = running_q[addr_q];
	assign cur_mark    = mark_q[addr_q];

	// One multiplier serves both scaling steps; only the low word is kept.
	always_comb begin
		if (state_q == ST_MUL2) begin
			mul_a = ticks_sel;
			mul_b = cpu_hz_q;
		end else begin
			mul_a = now_q - base_q;
			mul_b = {{(DATA_W-TICK_W){1'b0}}, tick_hz_q};
		end
	end
	assign mul_p = mul_a * mul_b;

	// Restoring divider, one quotient bit per cycle shifted into dnum_q.
	assign div_den      = (state_q == ST_DIV2) ? {{(DATA_W-TICK_W){1'b0}}, tick_hz_q}
	                                           : cpu_hz_q;
	assign div_shift    = {drem_q, dnum_q[DATA_W-1]};
	assign div_diff     = {1'b0, div_shift} - {2'b0, div_den};
	assign div_ge       = ~div_diff[DATA_W+1];
	assign div_rem_next = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];

	// A zero divisor yields a zero quotient.
	assign ticks_sel = (cpu_hz_q == '0) ? '0 : dnum_q;
	assign cyc_sel   = (tick_hz_q == '0) ? '0 : dnum_q;

	assign poll_diff = tod_q - dl_rdata_q;
	assign poll_hit  = ~poll_diff[DATA_W-1];

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dl_rdata_q <= dl_mem[rd_addr];
		end
		if (state_q == ST_FIN && out_free && idx_valid && act_q == ACT_START
				&& !cur_running) begin
			dl_mem[addr_q] <= tod_q + delay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_hz_q   <= CPU_HZ_RST;
			tick_hz_q  <= TICK_HZ_RST;
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			running_q  <= '0;
			mark_q     <= '0;
			tod_q      <= '0;
			base_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_CPU_HZ:  cpu_hz_q  <= pwdata;
					REG_TICK_HZ: tick_hz_q <= pwdata[TICK_W-1:0];
					default:     ;
				endcase
			end
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (idx_valid && act_q == ACT_START && !cur_running) begin
						state_q <= ST_MUL1;
					end else if (idx_valid && act_q == ACT_POLL && !cur_mark
							&& cur_running) begin
						state_q <= ST_MUL1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MUL1: begin
					cnt_q   <= '0;
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastStep) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					cnt_q   <= '0;
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastStep) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					tod_q   <= tod_q + ticks_q;
					base_q  <= base_q + cyc_sel;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
						if (act_q == ACT_SETUP) begin
							base_q <= now_q;
						end else if (idx_valid) begin
							case (act_q)
								ACT_START: begin
									if (!cur_running) begin
										running_q[addr_q] <= 1'b1;
										mark_q[addr_q]    <= 1'b0;
									end
								end
								ACT_STOP: begin
									running_q[addr_q] <= 1'b0;
									mark_q[addr_q]    <= 1'b0;
								end
								ACT_POLL: begin
									if (!cur_mark && cur_running && poll_hit) begin
										mark_q[addr_q] <= 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q   <= action_t'(s_tdata[1:0]);
			idx_q   <= s_tdata[5:2];
			delay_q <= s_tdata[37:6];
			now_q   <= s_tdata[69:38];
		end
		case (state_q)
			ST_MUL1: begin
				dnum_q <= mul_p;
				drem_q <= '0;
			end
			ST_MUL2: begin
				ticks_q <= ticks_sel;
				dnum_q  <= mul_p;
				drem_q  <= '0;
			end
			ST_DIV1, ST_DIV2: begin
				dnum_q <= {dnum_q[DATA_W-2:0], div_ge};
				drem_q <= div_rem_next;
			end
			ST_FIN: begin
				if (out_free) begin
					out_time_q <= tod_q;
					out_exp_q  <= (act_q == ACT_POLL) && idx_valid
						&& (cur_mark || (cur_running && poll_hit));
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### bench/one_shot_timer_bank_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module one_shot_timer_bank_top_tb;
	import ostb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int HOLD_CYCLES    = 500;
	localparam logic [31:0] DEF_TICK_CYCLES = 32'd48000;

	typedef struct packed {
		logic        expired;
		logic [31:0] time_now;
	} timer_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	// s_tdata: action[1:0], timer_index[5:2], delay_value[37:6], cycle_count[69:38], zero pad
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// m_tdata: expired[0], time_now[32:1], zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Timer bank state as the block should hold it.
	logic [31:0] cpu_hz_model  = CPU_HZ_RST;
	logic [31:0] tick_hz_model = 32'(TICK_HZ_RST);
	logic [31:0] deadline_model [NUM_TIMERS_DEF];
	logic [NUM_TIMERS_DEF-1:0] running_model = '0;
	logic [NUM_TIMERS_DEF-1:0] mark_model    = '0;
	logic [31:0] tod_model  = '0;
	logic [31:0] base_model = '0;

	timer_result_t pending_results [$];
	timer_result_t oldest_result;
	int          error_count = 0;
	int          idle_cycles = 0;
	bit          send_idle_en = 1'b1;
	bit          recv_idle_en = 1'b1;
	int          hold_off_cycles = 0;
	logic [31:0] cycle_clock = '0;

	one_shot_timer_bank_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [31:0] div_or_zero(logic [31:0] num, logic [31:0] den);
		return (den == 32'd0) ? 32'd0 : num / den;
	endfunction

	// Whole ticks are taken from the elapsed cycles; the base keeps the remainder.
	function automatic void advance_tod(logic [31:0] now);
		logic [31:0] delta;
		logic [31:0] scaled;
		logic [31:0] ticks;
		logic [31:0] used;
		delta = now - base_model;
		scaled = delta * tick_hz_model;
		ticks = div_or_zero(scaled, cpu_hz_model);
		used = ticks * cpu_hz_model;
		base_model = base_model + div_or_zero(used, tick_hz_model);
		tod_model = tod_model + ticks;
	endfunction

	function automatic timer_result_t predict_timer(action_t act, logic [3:0] idx,
			logic [31:0] delay, logic [31:0] now);
		timer_result_t res;
		logic [31:0] diff;
		res.expired = 1'b0;
		case (act)
			ACT_SETUP: begin
				base_model = now;
			end
			ACT_START: begin
				if (!running_model[idx]) begin
					advance_tod(now);
					deadline_model[idx] = tod_model + delay;
					mark_model[idx] = 1'b0;
					running_model[idx] = 1'b1;
				end
			end
			ACT_STOP: begin
				mark_model[idx] = 1'b0;
				running_model[idx] = 1'b0;
			end
			default: begin
				if (mark_model[idx]) begin
					res.expired = 1'b1;
				end else if (running_model[idx]) begin
					advance_tod(now);
					diff = tod_model - deadline_model[idx];
					if (!diff[31]) begin
						mark_model[idx] = 1'b1;
						res.expired = 1'b1;
					end
				end
			end
		endcase
		res.time_now = tod_model;
		return res;
	endfunction

	function automatic int draw_gap(bit enabled);
		return enabled ? $urandom_range(0, 19) : 0;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_transfer(action_t act, logic [3:0] idx, logic [31:0] delay,
			logic [31:0] now);
		int gap;
		gap = draw_gap(send_idle_en);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {2'b00, now, delay, idx, act};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_timer(act, idx, delay, now));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Leaves psel high so that accesses can follow back to back; the caller ends the run.
	task automatic apb_access(bit wr, reg_index_t r, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
	endtask

	task automatic set_rates(logic [31:0] cpu, logic [19:0] tick);
		logic [31:0] rd;
		wait_idle();
		apb_access(1'b1, REG_CPU_HZ, cpu, rd);
		cpu_hz_model = cpu;
		apb_access(1'b1, REG_TICK_HZ, 32'(tick), rd);
		tick_hz_model = 32'(tick);
		apb_access(1'b0, REG_CPU_HZ, '0, rd);
		if (rd !== cpu) begin
			$error("cpu_hz readback: expected %0h, actual %0h", cpu, rd);
			error_count++;
		end
		apb_access(1'b0, REG_TICK_HZ, '0, rd);
		if (rd !== 32'(tick)) begin
			$error("tick_hz readback: expected %0h, actual %0h", 32'(tick), rd);
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly a cycle counter that moves on by about one tick per transfer, so timers
	// started with short delays get polled through to expiry; the rest is noise.
	task automatic run_random(int count);
		logic [63:0] tick_cycles;
		logic [31:0] now;
		logic [31:0] delay;
		logic [3:0]  idx;
		action_t     act;
		int          pick;
		tick_cycles = (tick_hz_model == 0 || cpu_hz_model == 0) ? 64'd1000 :
			64'(cpu_hz_model / tick_hz_model);
		if (tick_cycles == 0) tick_cycles = 64'd1;
		if (tick_cycles > 64'h3FFF_FFFF) tick_cycles = 64'h3FFF_FFFF;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) act = ACT_SETUP;
			else if (pick < 35) act = ACT_START;
			else if (pick < 48) act = ACT_STOP;
			else act = ACT_POLL;
			idx = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 70) delay = $urandom_range(0, 8);
			else if (pick < 85) delay = -$urandom_range(1, 4);
			else delay = $urandom;
			if ($urandom_range(0, 99) < 85) begin
				cycle_clock = cycle_clock + 32'($urandom_range(0, 32'(2 * tick_cycles)));
				now = cycle_clock;
			end else begin
				now = $urandom;
			end
			send_transfer(act, idx, delay, now);
		end
	endtask

	task automatic test_directed();
		send_transfer(ACT_POLL, 4'd0, 32'd0, 32'd0);
		send_transfer(ACT_STOP, 4'd15, 32'd0, 32'd0);
		send_transfer(ACT_SETUP, 4'd0, 32'd0, 32'd0);
		send_transfer(ACT_START, 4'd0, 32'd5, DEF_TICK_CYCLES + 32'd100);
		// A second start on a running timer is ignored.
		send_transfer(ACT_START, 4'd0, 32'd100, DEF_TICK_CYCLES * 9);
		send_transfer(ACT_POLL, 4'd0, 32'd0, DEF_TICK_CYCLES * 4);
		send_transfer(ACT_POLL, 4'd0, 32'd0, DEF_TICK_CYCLES * 6);
		// The sticky mark answers without moving time on.
		send_transfer(ACT_POLL, 4'd0, 32'd0, DEF_TICK_CYCLES * 100);
		send_transfer(ACT_STOP, 4'd0, 32'd0, 32'd0);
		send_transfer(ACT_POLL, 4'd0, 32'd0, DEF_TICK_CYCLES * 101);
		send_transfer(ACT_START, 4'd15, 32'd0, DEF_TICK_CYCLES * 7);
		send_transfer(ACT_POLL, 4'd15, 32'd0, DEF_TICK_CYCLES * 7);
		send_transfer(ACT_START, 4'd1, 32'h8000_0000, DEF_TICK_CYCLES * 8);
		send_transfer(ACT_POLL, 4'd1, 32'd0, DEF_TICK_CYCLES * 9);
		send_transfer(ACT_START, 4'd2, 32'h7FFF_FFFF, DEF_TICK_CYCLES * 10);
		send_transfer(ACT_POLL, 4'd2, 32'd0, 32'hFFFF_FFFF);
		send_transfer(ACT_START, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_transfer(ACT_POLL, 4'd3, 32'd0, 32'hFFFF_FFFF);
		send_transfer(ACT_SETUP, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// The cycle count wraps between base and now.
		send_transfer(ACT_START, 4'd4, 32'd2, DEF_TICK_CYCLES * 2 - 32'd1);
		send_transfer(ACT_POLL, 4'd4, 32'd0, DEF_TICK_CYCLES * 4);
		send_transfer(ACT_POLL, 4'd4, 32'd0, DEF_TICK_CYCLES * 5);
		cycle_clock = DEF_TICK_CYCLES * 5;
		wait_idle();
	endtask

	task automatic test_rate_settings();
		set_rates(32'd48000000, 20'd1000);
		run_random(170);
		set_rates(32'd1, 20'd1);
		run_random(170);
		set_rates(32'hFFFF_FFFF, 20'd1000000);
		run_random(170);
		set_rates(32'd1, 20'd1000000);
		run_random(170);
		set_rates(32'hFFFF_FFFF, 20'd1);
		run_random(170);
		set_rates(32'd12000000, 20'd32768);
		run_random(170);
		// A zero rate on either side leaves time frozen.
		set_rates(32'd0, 20'd1000);
		run_random(60);
		set_rates(32'd48000000, 20'd0);
		run_random(60);
		set_rates(32'd1000, 20'd999999);
		run_random(170);
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_rates(32'd48000000, 20'd1000);
		send_idle_en = 1'b0;
		hold_off_cycles = HOLD_CYCLES;
		run_random(40);
		send_idle_en = 1'b1;
		wait_idle();
	endtask

	task automatic test_no_idle();
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		run_random(150);
		wait_idle();
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_rate_settings();
		test_backpressure();
		test_no_idle();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Result side: a random stall per transfer, and one long hold-off on request.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
			end
			stall = draw_gap(recv_idle_en);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: time_now %0h", m_tdata[32:1]);
				error_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (m_tdata[0] !== oldest_result.expired) begin
					$error("expired: expected %0d, actual %0d",
						oldest_result.expired, m_tdata[0]);
					error_count++;
				end
				if (m_tdata[32:1] !== oldest_result.time_now) begin
					$error("time_now: expected %0h, actual %0h",
						oldest_result.time_now, m_tdata[32:1]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
`default_nettype wire
